@@ hdl/plti_pkg.sv @@
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types and constants of the piecewise-linear interpolation table:
// word layouts, opcodes, region codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package plti_pkg;

    localparam int FIXED_WIDTH      = 32;
    localparam int DEF_TABLE_POINTS = 512;
    localparam int IDX_W            = 9;
    localparam int PIU_W            = 10;

    localparam logic [PIU_W-1:0] PIU_RESET = PIU_W'(2);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REGION_INSIDE = 2'd0;
    localparam logic [1:0] REGION_ABOVE  = 2'd1;
    localparam logic [1:0] REGION_BELOW  = 2'd2;

    typedef struct packed {
        logic                          opcode;
        logic [IDX_W-1:0]              entry_index;
        logic signed [FIXED_WIDTH-1:0] position;
        logic signed [FIXED_WIDTH-1:0] entry_value;
    } item_t;

    typedef struct packed {
        logic signed [FIXED_WIDTH-1:0] interpolated_value;
        logic [1:0]                    region;
    } result_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic rdv0;
        logic rdv1;
        logic setup;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic fin;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic direct;
        logic cnt_last;
    } dp_status_t;

endpackage

@@ hdl/piecewise_linear_table_interp_top.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_top
// Piecewise-linear lookup table with interpolation over signed Q16.16
// breakpoints.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present a request word and raise start; the word is taken
//   at the rising edge where start is high and busy is low.
//   - A write word (opcode write) stores one breakpoint at entry_index in
//     that same edge, returns nothing and leaves busy low, so writes can
//     stream one per cycle outside queries. Writes beyond the table are dropped.
//   - A query word raises busy until its result word has been strobed.
//   Result channel: done is high for exactly one cycle with the result word
//   valid; the receiver cannot stall it and must take it then.
//   Configuration: cfg_we writes points_in_use (clamped to 2..TABLE_POINTS);
//   the user must raise it only while idle; the block does not enforce this.
//   Sequence: the query scans the n breakpoints in use, one memory read per
//   cycle, fetches the two segment values, then runs a FIXED_WIDTH-step
//   shift-add multiply and a (2*FIXED_WIDTH+2)-step restoring divide whose
//   quotient is the Q16.16 result. Queries that clamp to an end, match no
//   segment or fall on a zero-width segment skip the arithmetic.
//   The next word is taken the cycle after the result strobe.
//   Reset: points_in_use returns to 2; table contents stay undefined until
//   written.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_top #(
    parameter int TABLE_POINTS = plti_pkg::DEF_TABLE_POINTS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  plti_pkg::item_t            request,
    output logic                       done,
    output plti_pkg::result_t          result,
    input  logic                       cfg_we,
    input  logic [plti_pkg::PIU_W-1:0] cfg_wdata
);

    plti_pkg::dp_cmd_t    cmd;
    plti_pkg::dp_status_t status;
    logic                 accept;
    logic                 query;

    // Take a word whenever idle; only queries start the sequencer.
    assign accept = start && !busy;
    assign query  = accept && (request.opcode == plti_pkg::OP_QUERY);

    plti_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    plti_dp #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .item      (request),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

@@ hdl/plti_dp.sv @@
// ----------------------------------------------------------------------------
// plti_dp
// Datapath: breakpoint memories, segment scan, shift-add blend multiplier
// and restoring divider for the interpolation table.
// ----------------------------------------------------------------------------
module plti_dp #(
    parameter int TABLE_POINTS = plti_pkg::DEF_TABLE_POINTS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [plti_pkg::PIU_W-1:0] cfg_wdata,
    input  logic                       accept,
    input  plti_pkg::item_t            item,
    input  plti_pkg::dp_cmd_t          cmd,
    output plti_pkg::dp_status_t       status,
    output plti_pkg::result_t          result
);

    localparam int FW = plti_pkg::FIXED_WIDTH;
    localparam int NW = 2 * FW + 2;
    localparam int AW = $clog2(TABLE_POINTS);
    localparam int IW = (AW + 1 > plti_pkg::IDX_W) ? AW + 1 : plti_pkg::IDX_W;
    localparam int CW = ($clog2(TABLE_POINTS + 1) > plti_pkg::PIU_W) ?
                        $clog2(TABLE_POINTS + 1) : plti_pkg::PIU_W;
    localparam int KW = $clog2(NW);

    logic [FW-1:0] pos_mem [TABLE_POINTS];
    logic [FW-1:0] val_mem [TABLE_POINTS];

    logic [plti_pkg::PIU_W-1:0] piu_reg;
    logic                       pd_valid_reg;
    logic [AW-1:0]              pd_idx_reg;
    logic [AW-1:0]              scan_idx_reg;
    logic [AW-1:0]              n_last_reg;
    logic [FW-1:0]              pos_reg;
    logic [FW-1:0]              pos_rd_reg;
    logic [FW-1:0]              val_rd_reg;
    logic [FW-1:0]              first_reg;
    logic [FW-1:0]              prev_reg;
    logic                       matched_reg;
    logic [AW-1:0]              match_idx_reg;
    logic [FW-1:0]              w_reg;
    logic [FW-1:0]              o_reg;
    logic [1:0]                 region_reg;
    logic [AW-1:0]              a0_reg;
    logic [AW-1:0]              a1_reg;
    logic                       direct_reg;
    logic [FW-1:0]              v0_reg;
    logic [FW-1:0]              v1_reg;
    logic [FW-1:0]              wa_reg;
    logic [FW-1:0]              wb_reg;
    logic [NW-1:0]              acc_reg;
    logic [FW-1:0]              rem_reg;
    logic [FW-1:0]              quo_reg;
    logic                       neg_reg;
    logic [KW-1:0]              cnt_reg;
    logic [FW-1:0]              result_reg;

    logic [IW-1:0] widx;
    logic [AW-1:0] waddr;
    logic          wr_en;
    logic [CW-1:0] n_ext;
    logic [CW-1:0] n_clamp;
    logic          seg_hit;
    logic          above;
    logic          below;
    logic [AW-1:0] vaddr;
    logic [NW-1:0] v0_ext;
    logic [NW-1:0] v1_ext;
    logic [NW-1:0] acc_next;
    logic [NW-1:0] acc_mag;
    logic [FW:0]   div_t;
    logic [FW:0]   div_diff;
    logic          div_ge;

    // Write decode: drop writes beyond the table.
    assign widx  = IW'(item.entry_index);
    assign waddr = widx[AW-1:0];
    assign wr_en = accept && (item.opcode == plti_pkg::OP_WRITE)
                   && (widx < IW'(TABLE_POINTS));

    // Clamp the breakpoint count into [2, TABLE_POINTS].
    always_comb
    begin
        n_ext = CW'(piu_reg);
        if (n_ext < CW'(2))
            n_clamp = CW'(2);
        else if (n_ext > CW'(TABLE_POINTS))
            n_clamp = CW'(TABLE_POINTS);
        else
            n_clamp = n_ext;
    end

    assign seg_hit = pd_valid_reg && (pd_idx_reg != '0)
                     && ($signed(pos_reg) >= $signed(prev_reg))
                     && ($signed(pos_reg) <= $signed(pos_rd_reg));

    assign above = $signed(pos_reg) > $signed(prev_reg);
    assign below = $signed(pos_reg) < $signed(first_reg);
    assign vaddr = cmd.rdv0 ? a0_reg : a1_reg;

    assign v0_ext = {{(NW - FW){v0_reg[FW-1]}}, v0_reg};
    assign v1_ext = {{(NW - FW){v1_reg[FW-1]}}, v1_reg};

    always_comb
    begin
        acc_next = {acc_reg[NW-2:0], 1'b0};
        if (wa_reg[FW-1])
            acc_next = acc_next + v0_ext;
        if (wb_reg[FW-1])
            acc_next = acc_next + v1_ext;
    end

    assign acc_mag  = acc_reg[NW-1] ? ('0 - acc_reg) : acc_reg;
    assign div_t    = {rem_reg, acc_reg[NW-1]};
    assign div_diff = div_t - {1'b0, w_reg};
    assign div_ge   = div_t >= {1'b0, w_reg};

    // Breakpoint memories, registered reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[waddr] <= item.position;
            val_mem[waddr] <= item.entry_value;
        end
        if (cmd.scan)
            pos_rd_reg <= pos_mem[scan_idx_reg];
        if (cmd.rdv0 || cmd.rdv1)
            val_rd_reg <= val_mem[vaddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piu_reg      <= plti_pkg::PIU_RESET;
            pd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                piu_reg <= cfg_wdata;
            pd_valid_reg <= cmd.scan;
        end
    end

    always_ff @(posedge clk)
    begin
        pd_idx_reg <= scan_idx_reg;

        if (cmd.load)
        begin
            pos_reg       <= item.position;
            n_last_reg    <= AW'(n_clamp - CW'(1));
            scan_idx_reg  <= '0;
            matched_reg   <= 1'b0;
            match_idx_reg <= '0;
        end
        else if (cmd.scan)
            scan_idx_reg <= scan_idx_reg + AW'(1);

        // Track first and previous positions; keep the last hit segment.
        if (pd_valid_reg)
        begin
            prev_reg <= pos_rd_reg;
            if (pd_idx_reg == '0)
                first_reg <= pos_rd_reg;
        end
        if (seg_hit)
        begin
            matched_reg   <= 1'b1;
            match_idx_reg <= pd_idx_reg - AW'(1);
            w_reg         <= pos_rd_reg - prev_reg;
            o_reg         <= pos_reg - prev_reg;
        end

        if (cmd.decide)
        begin
            a1_reg <= match_idx_reg + AW'(1);
            if (above)
            begin
                region_reg <= plti_pkg::REGION_ABOVE;
                a0_reg     <= n_last_reg;
            end
            else if (below)
            begin
                region_reg <= plti_pkg::REGION_BELOW;
                a0_reg     <= '0;
            end
            else
            begin
                region_reg <= plti_pkg::REGION_INSIDE;
                a0_reg     <= matched_reg ? match_idx_reg : '0;
            end
            direct_reg <= above || below || !matched_reg || (w_reg == '0);
        end

        if (cmd.rdv1)
            v0_reg <= val_rd_reg;

        if (cmd.setup)
        begin
            v1_reg <= val_rd_reg;
            if (direct_reg)
                result_reg <= v0_reg;
            acc_reg <= '0;
            wa_reg  <= w_reg - o_reg;
            wb_reg  <= o_reg;
            cnt_reg <= KW'(FW - 1);
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= acc_next;
            wa_reg  <= {wa_reg[FW-2:0], 1'b0};
            wb_reg  <= {wb_reg[FW-2:0], 1'b0};
            cnt_reg <= cnt_reg - KW'(1);
        end
        else if (cmd.div_init)
        begin
            neg_reg <= acc_reg[NW-1];
            acc_reg <= acc_mag;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= KW'(NW - 1);
        end
        else if (cmd.div_step)
        begin
            acc_reg <= {acc_reg[NW-2:0], 1'b0};
            rem_reg <= div_ge ? div_diff[FW-1:0] : div_t[FW-1:0];
            quo_reg <= {quo_reg[FW-2:0], div_ge};
            cnt_reg <= cnt_reg - KW'(1);
        end

        if (cmd.fin)
            result_reg <= neg_reg ? ('0 - quo_reg) : quo_reg;
    end

    assign status.scan_last = scan_idx_reg == n_last_reg;
    assign status.direct    = direct_reg;
    assign status.cnt_last  = cnt_reg == '0;

    assign result.interpolated_value = result_reg;
    assign result.region             = region_reg;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (scan_idx_reg <= n_last_reg))
        else $error("scan read past the last breakpoint in use");

    a_rem_below_width: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < w_reg))
        else $error("divider remainder not below segment width");

endmodule

@@ hdl/plti_ctrl.sv @@
// ----------------------------------------------------------------------------
// plti_ctrl
// Controller: sequences one query through scan, value fetch and (unless the
// result is direct) blend multiply and divide, then strobes the result word.
// ----------------------------------------------------------------------------
module plti_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 query,
    input  plti_pkg::dp_status_t status,
    output plti_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_RDV0,
        S_RDV1,
        S_SETUP,
        S_MUL,
        S_DIVI,
        S_DIV,
        S_FIN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (query)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_DECIDE;
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_RDV0;
            end
            S_RDV0:
            begin
                cmd.rdv0   = 1'b1;
                state_next = S_RDV1;
            end
            S_RDV1:
            begin
                cmd.rdv1   = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.direct ? S_DONE : S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (status.cnt_last)
                    state_next = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.cnt_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= state_next != S_IDLE;
            done_reg  <= state_next == S_DONE;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a query");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_busy_ends_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("query ended without a result word");

endmodule
